// ===== src/elkv_pkg.sv =====
// ----------------------------------------------------------------------------
// elkv_pkg
// Shared constants, types and helper functions for the entity lump parser.
// ----------------------------------------------------------------------------
package elkv_pkg;

  localparam int ADDR_BITS = 20;
  localparam int MAX_ENTS  = 8192;
  localparam int MAX_PROPS = 64;

  localparam int POS_W  = ADDR_BITS + 1;
  localparam int ENT_W  = $clog2(MAX_ENTS + 1);
  localparam int PROP_W = $clog2(MAX_PROPS + 1);

  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 4;
  localparam int OFS_W      = 20;
  localparam int ENT_IDX_W  = 13;
  localparam int PROP_IDX_W = 6;
  localparam int MATCH_W    = 4;

  localparam logic [MATCH_W-1:0] CLS_LEN = MATCH_W'(9);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7d;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;

  localparam logic [CODE_W-1:0] EV_PROPERTY   = 4'd0;
  localparam logic [CODE_W-1:0] EV_CLASSNAME  = 4'd1;
  localparam logic [CODE_W-1:0] EV_ENT_CLOSED = 4'd2;
  localparam logic [CODE_W-1:0] EV_CLEAN_END  = 4'd3;
  localparam logic [CODE_W-1:0] EV_UNEXP_END  = 4'd4;
  localparam logic [CODE_W-1:0] EV_BAD_TOKEN  = 4'd5;
  localparam logic [CODE_W-1:0] EV_NO_VALUE   = 4'd6;
  localparam logic [CODE_W-1:0] EV_ENT_LIMIT  = 4'd7;
  localparam logic [CODE_W-1:0] EV_PROP_FULL  = 4'd8;
  localparam logic [CODE_W-1:0] EV_TOO_LONG   = 4'd9;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_FIRSTQ   = 3'd1,
    PH_BODY     = 3'd2,
    PH_KEY      = 3'd3,
    PH_AFTERKEY = 3'd4,
    PH_VALUE    = 3'd5,
    PH_HALT     = 3'd6
  } phase_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13) ||
           (c == 8'd11) || (c == 8'd12);
  endfunction

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
  endfunction

  function automatic logic [BYTE_W-1:0] cls_char(input logic [MATCH_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6c; // l
      4'd2:    ch = 8'h61; // a
      4'd3:    ch = 8'h73; // s
      4'd4:    ch = 8'h73; // s
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h61; // a
      4'd7:    ch = 8'h6d; // m
      4'd8:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/entity_lump_kv_parser_core.sv =====
// ----------------------------------------------------------------------------
// entity_lump_kv_parser_core
// Byte-serial entity lump scanner: emits key/value offsets and lengths,
// entity close, clean end and error events.
// ----------------------------------------------------------------------------
// Pipeline: each input beat passes the input register, then the parse
//   logic into the result register.
// Throughput: 1 byte per cycle while out_ready is high; the parse state
//   registers feed back to themselves through combinational logic only.
// Reset: rst_n synchronous, active low; returns to entity start, position 0,
//   ignore_case set. After any error or clean end, bytes are consumed
//   silently until reset.
module entity_lump_kv_parser_core
  import elkv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_lump_byte,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CODE_W-1:0]      out_event_code,
  output logic [OFS_W-1:0]       out_key_start,
  output logic [OFS_W-1:0]       out_key_length,
  output logic [OFS_W-1:0]       out_value_start,
  output logic [OFS_W-1:0]       out_value_length,
  output logic [ENT_IDX_W-1:0]   out_entity_index,
  output logic [PROP_IDX_W-1:0]  out_property_index
);

  logic                  ignore_case_r;

  logic                  s1_valid_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic                  s1_go;

  phase_t                phase_r, phase_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [ADDR_BITS-1:0]  key_ofs_r, key_ofs_nxt;
  logic [ADDR_BITS-1:0]  key_len_r, key_len_nxt;
  logic [ADDR_BITS-1:0]  val_ofs_r, val_ofs_nxt;
  logic [MATCH_W-1:0]    match_r, match_nxt;
  logic                  alive_r, alive_nxt;
  logic                  cls_seen_r, cls_seen_nxt;
  logic [PROP_W-1:0]     props_r, props_nxt;
  logic [ENT_W-1:0]      ents_r, ents_nxt;

  logic                  emit;
  logic [CODE_W-1:0]     ev_code;
  logic [OFS_W-1:0]      ev_ks, ev_kl, ev_vs, ev_vl;
  logic [PROP_IDX_W-1:0] ev_pidx;

  logic [BYTE_W-1:0]     b;
  logic [ADDR_BITS-1:0]  pos_lo;
  logic [ADDR_BITS-1:0]  pos_inc;
  logic [BYTE_W-1:0]     got;

  logic                  out_valid_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [OFS_W-1:0]      out_ks_r, out_kl_r, out_vs_r, out_vl_r;
  logic [ENT_IDX_W-1:0]  out_eidx_r;
  logic [PROP_IDX_W-1:0] out_pidx_r;

  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_case_r <= 1'b1;
    end else if (cfg_wr_en) begin
      ignore_case_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_lump_byte;
    end
  end

  assign b       = s1_byte_r;
  assign pos_lo  = pos_r[ADDR_BITS-1:0];
  assign pos_inc = pos_lo + ADDR_BITS'(1);
  assign got     = ignore_case_r ? to_lower(b) : b;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    key_ofs_nxt  = key_ofs_r;
    key_len_nxt  = key_len_r;
    val_ofs_nxt  = val_ofs_r;
    match_nxt    = match_r;
    alive_nxt    = alive_r;
    cls_seen_nxt = cls_seen_r;
    props_nxt    = props_r;
    ents_nxt     = ents_r;
    emit         = 1'b0;
    ev_code      = EV_PROPERTY;
    ev_ks        = '0;
    ev_kl        = '0;
    ev_vs        = '0;
    ev_vl        = '0;
    ev_pidx      = '0;

    if (phase_r != PH_HALT) begin
      if (pos_r[ADDR_BITS]) begin
        emit      = 1'b1;
        ev_code   = EV_TOO_LONG;
        phase_nxt = PH_HALT;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        unique case (phase_r)
          PH_START: begin
            if (b == CH_NUL) begin
              emit      = 1'b1;
              ev_code   = EV_CLEAN_END;
              phase_nxt = PH_HALT;
            end else if (is_ws(b)) begin
              phase_nxt = PH_START;
            end else if (b == CH_LBRACE || b == CH_RBRACE) begin
              phase_nxt = PH_BODY;
            end else if (b == CH_QUOTE) begin
              phase_nxt = PH_FIRSTQ;
            end else begin
              emit      = 1'b1;
              ev_code   = EV_BAD_TOKEN;
              phase_nxt = PH_HALT;
            end
          end
          PH_FIRSTQ: begin
            if (b == CH_NUL) begin
              emit      = 1'b1;
              ev_code   = EV_CLEAN_END;
              phase_nxt = PH_HALT;
            end else if (b == CH_QUOTE) begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if (b == CH_NUL) begin
              emit      = 1'b1;
              ev_code   = EV_UNEXP_END;
              phase_nxt = PH_HALT;
            end else if (is_ws(b) || b == CH_LBRACE) begin
              phase_nxt = PH_BODY;
            end else if (b == CH_RBRACE) begin
              emit = 1'b1;
              if (ents_r >= ENT_W'(MAX_ENTS)) begin
                ev_code   = EV_ENT_LIMIT;
                phase_nxt = PH_HALT;
              end else begin
                ev_code      = EV_ENT_CLOSED;
                ents_nxt     = ents_r + ENT_W'(1);
                phase_nxt    = PH_START;
                cls_seen_nxt = 1'b0;
                props_nxt    = '0;
              end
            end else if (b == CH_QUOTE) begin
              key_ofs_nxt = pos_inc;
              match_nxt   = '0;
              alive_nxt   = 1'b1;
              phase_nxt   = PH_KEY;
            end else begin
              emit      = 1'b1;
              ev_code   = EV_BAD_TOKEN;
              phase_nxt = PH_HALT;
            end
          end
          PH_KEY: begin
            if (b == CH_NUL) begin
              emit      = 1'b1;
              ev_code   = EV_UNEXP_END;
              phase_nxt = PH_HALT;
            end else if (b == CH_QUOTE) begin
              key_len_nxt = pos_lo - key_ofs_r;
              phase_nxt   = PH_AFTERKEY;
            end else if (alive_r && match_r < CLS_LEN) begin
              if (got == cls_char(match_r)) begin
                match_nxt = match_r + MATCH_W'(1);
              end else begin
                alive_nxt = 1'b0;
              end
            end else begin
              alive_nxt = 1'b0;
            end
          end
          PH_AFTERKEY: begin
            if (is_ws(b)) begin
              phase_nxt = PH_AFTERKEY;
            end else if (b == CH_QUOTE) begin
              val_ofs_nxt = pos_inc;
              phase_nxt   = PH_VALUE;
            end else begin
              emit      = 1'b1;
              ev_code   = EV_NO_VALUE;
              phase_nxt = PH_HALT;
            end
          end
          PH_VALUE: begin
            if (b == CH_NUL) begin
              emit      = 1'b1;
              ev_code   = EV_NO_VALUE;
              phase_nxt = PH_HALT;
            end else if (b == CH_QUOTE) begin
              phase_nxt = PH_BODY;
              ev_ks     = key_ofs_r;
              ev_kl     = key_len_r;
              ev_vs     = val_ofs_r;
              ev_vl     = pos_lo - val_ofs_r;
              if (alive_r && match_r == CLS_LEN) begin
                if (!cls_seen_r) begin
                  cls_seen_nxt = 1'b1;
                  emit         = 1'b1;
                  ev_code      = EV_CLASSNAME;
                end
              end else if (props_r >= PROP_W'(MAX_PROPS)) begin
                emit      = 1'b1;
                ev_code   = EV_PROP_FULL;
                phase_nxt = PH_HALT;
                ev_ks     = '0;
                ev_kl     = '0;
                ev_vs     = '0;
                ev_vl     = '0;
              end else begin
                emit      = 1'b1;
                ev_code   = EV_PROPERTY;
                ev_pidx   = props_r[PROP_IDX_W-1:0];
                props_nxt = props_r + PROP_W'(1);
              end
            end
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      pos_r      <= '0;
      key_ofs_r  <= '0;
      key_len_r  <= '0;
      val_ofs_r  <= '0;
      match_r    <= '0;
      alive_r    <= 1'b1;
      cls_seen_r <= 1'b0;
      props_r    <= '0;
      ents_r     <= '0;
    end else if (s1_valid_r && s1_go) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      key_ofs_r  <= key_ofs_nxt;
      key_len_r  <= key_len_nxt;
      val_ofs_r  <= val_ofs_nxt;
      match_r    <= match_nxt;
      alive_r    <= alive_nxt;
      cls_seen_r <= cls_seen_nxt;
      props_r    <= props_nxt;
      ents_r     <= ents_nxt;
    end
  end

  // result register: loads a new beat, or drops the old one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go && emit) begin
      out_code_r <= ev_code;
      out_ks_r   <= ev_ks;
      out_kl_r   <= ev_kl;
      out_vs_r   <= ev_vs;
      out_vl_r   <= ev_vl;
      out_eidx_r <= ents_r[ENT_IDX_W-1:0];
      out_pidx_r <= ev_pidx;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_code     = out_code_r;
  assign out_key_start      = out_ks_r;
  assign out_key_length     = out_kl_r;
  assign out_value_start    = out_vs_r;
  assign out_value_length   = out_vl_r;
  assign out_entity_index   = out_eidx_r;
  assign out_property_index = out_pidx_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("parser left halt without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_code_r >= EV_CLEAN_END) |-> phase_r == PH_HALT)
    else $error("terminal event without halt");

  a_props_bound: assert property (@(posedge clk) disable iff (!rst_n)
    props_r <= PROP_W'(MAX_PROPS))
    else $error("property count beyond table size");

  a_ents_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ents_r <= ENT_W'(MAX_ENTS))
    else $error("entity count beyond limit");

endmodule

// ===== test/elkv_event_checker.sv =====
// ----------------------------------------------------------------------------
// elkv_event_checker
// Watches the byte, result and configuration ports of the entity lump
// parser, keeps its own model of the scan state, predicts any event beat
// that an accepted byte causes and compares every result beat, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module elkv_event_checker
  import elkv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_lump_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CODE_W-1:0]     out_event_code,
  input  logic [OFS_W-1:0]      out_key_start,
  input  logic [OFS_W-1:0]      out_key_length,
  input  logic [OFS_W-1:0]      out_value_start,
  input  logic [OFS_W-1:0]      out_value_length,
  input  logic [ENT_IDX_W-1:0]  out_entity_index,
  input  logic [PROP_IDX_W-1:0] out_property_index,
  output int                    fails,
  output int                    waiting
);

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic [OFS_W-1:0]      ks;
    logic [OFS_W-1:0]      kl;
    logic [OFS_W-1:0]      vs;
    logic [OFS_W-1:0]      vl;
    logic [ENT_IDX_W-1:0]  ent;
    logic [PROP_IDX_W-1:0] pidx;
  } lump_ev_t;

  localparam logic [8*9-1:0] CLASS_WORD = "classname";

  lump_ev_t           event_q[$];
  logic               fold_case;
  phase_t             ph;
  logic [ADDR_BITS:0] byte_pos;
  logic [ADDR_BITS:0] key_ofs;
  logic [ADDR_BITS:0] key_len;
  logic [ADDR_BITS:0] val_ofs;
  logic [MATCH_W-1:0] mprog;
  logic               malive;
  logic               cls_seen;
  int                 props;
  int                 ents;

  function automatic logic blank(input logic [BYTE_W-1:0] c);
    case (c)
      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, output lump_ev_t ev);
    logic [ADDR_BITS:0] pos;
    logic [ADDR_BITS:0] vlen;
    logic [BYTE_W-1:0]  got;
    bit                 hit;
    ev     = '0;
    ev.ent = ents[ENT_IDX_W-1:0];
    hit    = 0;
    pos    = byte_pos;
    if (ph == PH_HALT) begin
      return 0;
    end
    if (pos[ADDR_BITS]) begin
      ev.code = EV_TOO_LONG;
      ph      = PH_HALT;
      return 1;
    end
    byte_pos = pos + 1'b1;
    case (ph)
      PH_START: begin
        if (b == CH_NUL) begin
          ev.code = EV_CLEAN_END; ph = PH_HALT; hit = 1;
        end else if (blank(b)) begin
        end else if (b == CH_LBRACE || b == CH_RBRACE) begin
          ph = PH_BODY;
        end else if (b == CH_QUOTE) begin
          ph = PH_FIRSTQ;
        end else begin
          ev.code = EV_BAD_TOKEN; ph = PH_HALT; hit = 1;
        end
      end
      PH_FIRSTQ: begin
        if (b == CH_NUL) begin
          ev.code = EV_CLEAN_END; ph = PH_HALT; hit = 1;
        end else if (b == CH_QUOTE) begin
          ph = PH_BODY;
        end
      end
      PH_BODY: begin
        if (b == CH_NUL) begin
          ev.code = EV_UNEXP_END; ph = PH_HALT; hit = 1;
        end else if (blank(b) || b == CH_LBRACE) begin
        end else if (b == CH_RBRACE) begin
          hit = 1;
          if (ents >= MAX_ENTS) begin
            ev.code = EV_ENT_LIMIT; ph = PH_HALT;
          end else begin
            ev.code  = EV_ENT_CLOSED;
            ents     = ents + 1;
            ph       = PH_START;
            cls_seen = 1'b0;
            props    = 0;
          end
        end else if (b == CH_QUOTE) begin
          key_ofs = pos + 1'b1;
          mprog   = '0;
          malive  = 1'b1;
          ph      = PH_KEY;
        end else begin
          ev.code = EV_BAD_TOKEN; ph = PH_HALT; hit = 1;
        end
      end
      PH_KEY: begin
        if (b == CH_NUL) begin
          ev.code = EV_UNEXP_END; ph = PH_HALT; hit = 1;
        end else if (b == CH_QUOTE) begin
          key_len = pos - key_ofs;
          ph      = PH_AFTERKEY;
        end else if (malive && mprog < 4'd9) begin
          got = fold_case ? fold(b) : b;
          if (got == CLASS_WORD[8*(8-mprog) +: 8]) begin
            mprog = mprog + 1'b1;
          end else begin
            malive = 1'b0;
          end
        end else begin
          malive = 1'b0;
        end
      end
      PH_AFTERKEY: begin
        if (blank(b)) begin
        end else if (b == CH_QUOTE) begin
          val_ofs = pos + 1'b1;
          ph      = PH_VALUE;
        end else begin
          ev.code = EV_NO_VALUE; ph = PH_HALT; hit = 1;
        end
      end
      PH_VALUE: begin
        if (b == CH_NUL) begin
          ev.code = EV_NO_VALUE; ph = PH_HALT; hit = 1;
        end else if (b == CH_QUOTE) begin
          vlen = pos - val_ofs;
          ph   = PH_BODY;
          if (malive && mprog == 4'd9) begin
            if (!cls_seen) begin
              cls_seen = 1'b1;
              hit      = 1;
              ev.code  = EV_CLASSNAME;
              ev.ks    = key_ofs[OFS_W-1:0];
              ev.kl    = key_len[OFS_W-1:0];
              ev.vs    = val_ofs[OFS_W-1:0];
              ev.vl    = vlen[OFS_W-1:0];
            end
          end else if (props >= MAX_PROPS) begin
            ev.code = EV_PROP_FULL; ph = PH_HALT; hit = 1;
          end else begin
            hit     = 1;
            ev.code = EV_PROPERTY;
            ev.ks   = key_ofs[OFS_W-1:0];
            ev.kl   = key_len[OFS_W-1:0];
            ev.vs   = val_ofs[OFS_W-1:0];
            ev.vl   = vlen[OFS_W-1:0];
            ev.pidx = props[PROP_IDX_W-1:0];
            props   = props + 1;
          end
        end
      end
      default: ph = PH_HALT;
    endcase
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    lump_ev_t ev;
    lump_ev_t want;
    if (!rst_n) begin
      fold_case = 1'b1;
      ph        = PH_START;
      byte_pos  = '0;
      key_ofs   = '0;
      key_len   = '0;
      val_ofs   = '0;
      mprog     = '0;
      malive    = 1'b1;
      cls_seen  = 1'b0;
      props     = 0;
      ents      = 0;
      event_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          $error("result beat with nothing expected: event_code %0d", out_event_code);
          fails++;
        end else begin
          want = event_q.pop_front();
          check_field("event_code", want.code, out_event_code);
          check_field("key_start", want.ks, out_key_start);
          check_field("key_length", want.kl, out_key_length);
          check_field("value_start", want.vs, out_value_start);
          check_field("value_length", want.vl, out_value_length);
          check_field("entity_index", want.ent, out_entity_index);
          check_field("property_index", want.pidx, out_property_index);
        end
      end
      if (cfg_wr_en) begin
        fold_case = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        if (scan_byte(in_lump_byte, ev)) begin
          event_q.push_back(ev);
        end
      end
    end
    waiting = event_q.size();
  end

endmodule

// ===== test/tb_entity_lump_kv_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_entity_lump_kv_parser_core
// Streams one long entity lump into the parser: a short hand-written entity,
// then random well-formed entities (mixed-case and near-miss classname keys,
// repeated classnames, a full property table, stray braces, whitespace),
// with the case-folding register changed between segments, and finally one
// randomly chosen lump ending or error followed by bytes that must be
// swallowed. Both handshakes idle in random bursts; the result side stalls
// once for long enough to back the block up. Checking is done by
// elkv_event_checker.
// ----------------------------------------------------------------------------
module tb_entity_lump_kv_parser_core;
  import elkv_pkg::*;

  localparam int ITEMS = 1150;
  localparam int LIMIT = 400000;

  typedef enum int {
    KEY_PLAIN,
    KEY_CLASS,
    KEY_NEAR
  } key_kind_t;

  typedef enum int {
    END_CLEAN,
    END_NUL_FIRSTQ,
    END_BAD_FIRST,
    END_NUL_BODY,
    END_NUL_KEY,
    END_BAD_BODY,
    END_BAD_AFTERKEY,
    END_NUL_AFTERKEY,
    END_NUL_VALUE,
    END_PROPS_FULL
  } lump_end_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  cfg_wr_en    = 1'b0;
  logic                  cfg_wr_data  = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_lump_byte = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [CODE_W-1:0]     out_event_code;
  logic [OFS_W-1:0]      out_key_start;
  logic [OFS_W-1:0]      out_key_length;
  logic [OFS_W-1:0]      out_value_start;
  logic [OFS_W-1:0]      out_value_length;
  logic [ENT_IDX_W-1:0]  out_entity_index;
  logic [PROP_IDX_W-1:0] out_property_index;

  int fails;
  int waiting;
  int n_sent      = 0;
  int cyc         = 0;
  bit calm        = 0;
  bit in_idle_on  = 1;
  bit out_idle_on = 1;
  bit squeeze_req = 0;
  bit squeezed    = 0;

  entity_lump_kv_parser_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lump_byte       (in_lump_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_code     (out_event_code),
    .out_key_start      (out_key_start),
    .out_key_length     (out_key_length),
    .out_value_start    (out_value_start),
    .out_value_length   (out_value_length),
    .out_entity_index   (out_entity_index),
    .out_property_index (out_property_index)
  );

  elkv_event_checker kv_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lump_byte       (in_lump_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_code     (out_event_code),
    .out_key_start      (out_key_start),
    .out_key_length     (out_key_length),
    .out_value_start    (out_value_start),
    .out_value_length   (out_value_length),
    .out_entity_index   (out_entity_index),
    .out_property_index (out_property_index),
    .fails              (fails),
    .waiting            (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus one long hold to fill the block
  initial begin : drain
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (!calm && out_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one byte beat; entered and left at a falling edge
  task automatic put(input logic [BYTE_W-1:0] b);
    if (!calm && in_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_lump_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return 8'd32;
      1: return 8'd9;
      2: return 8'd10;
      3: return 8'd13;
      4: return 8'd11;
      default: return 8'd12;
    endcase
  endfunction

  // any byte allowed inside a quoted string
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = $urandom_range(1, 255); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic int text_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
  endfunction

  task automatic put_gap(input int max);
    repeat ($urandom_range(0, max)) put(blank_byte());
  endtask

  task automatic put_word(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_quoted(input int len);
    put(CH_QUOTE);
    repeat (len) put(text_byte());
    put(CH_QUOTE);
  endtask

  task automatic put_pair(input key_kind_t kind, input bit short_pair);
    string             w;
    logic [BYTE_W-1:0] ch;
    bit                mixed;
    int                cut;
    w = "classname";
    put(CH_QUOTE);
    case (kind)
      KEY_CLASS: begin
        mixed = $urandom_range(0, 1);
        for (int i = 0; i < 9; i++) begin
          ch = w[i];
          if (mixed && $urandom_range(0, 1)) ch = ch - 8'd32;
          put(ch);
        end
      end
      KEY_NEAR: begin
        case ($urandom_range(0, 2))
          0: begin
            cut = $urandom_range(0, 8);
            for (int i = 0; i < cut; i++) put(w[i]);
          end
          1: begin
            put_word(w);
            put(text_byte());
          end
          default: begin
            put(text_byte());
            put_word(w);
          end
        endcase
      end
      default: repeat (short_pair ? $urandom_range(0, 1) : text_len()) put(text_byte());
    endcase
    put(CH_QUOTE);
    put_gap(short_pair ? 0 : 2);
    put_quoted(short_pair ? $urandom_range(0, 1) : text_len());
  endtask

  task automatic put_entity(input int pairs, input bit full_table);
    int        r;
    key_kind_t kind;
    put_gap(2);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      put(CH_RBRACE);
    end else if (r == 1) begin
      put_quoted($urandom_range(0, 4));
    end else begin
      put(CH_LBRACE);
    end
    for (int i = 0; i < pairs; i++) begin
      put_gap(full_table ? 0 : 2);
      if ($urandom_range(0, 7) == 0) put(CH_LBRACE);
      r = $urandom_range(0, 5);
      if (full_table || r > 2) begin
        kind = KEY_PLAIN;
      end else if (r == 2) begin
        kind = KEY_NEAR;
      end else begin
        kind = KEY_CLASS;
      end
      put_pair(kind, full_table);
    end
    put_gap(2);
    put(CH_RBRACE);
  endtask

  // let every beat in flight drain before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_fold(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic finish_lump(input lump_end_t how);
    case (how)
      END_CLEAN: begin
        put_gap(2);
        put(CH_NUL);
      end
      END_NUL_FIRSTQ: begin
        put(CH_QUOTE);
        repeat ($urandom_range(0, 3)) put(text_byte());
        put(CH_NUL);
      end
      END_BAD_FIRST: put($urandom_range(8'h41, 8'h7a));
      END_NUL_BODY: begin
        put(CH_LBRACE);
        put_pair(KEY_PLAIN, 0);
        put(CH_NUL);
      end
      END_NUL_KEY: begin
        put(CH_LBRACE);
        put(CH_QUOTE);
        repeat ($urandom_range(0, 3)) put(text_byte());
        put(CH_NUL);
      end
      END_BAD_BODY: begin
        put(CH_LBRACE);
        put_gap(1);
        put($urandom_range(8'h41, 8'h7a));
      end
      END_BAD_AFTERKEY: begin
        put(CH_LBRACE);
        put_quoted($urandom_range(0, 3));
        put_gap(1);
        put($urandom_range(8'h41, 8'h7a));
      end
      END_NUL_AFTERKEY: begin
        put(CH_LBRACE);
        put_quoted($urandom_range(0, 3));
        put(CH_NUL);
      end
      END_NUL_VALUE: begin
        put(CH_LBRACE);
        put_quoted($urandom_range(0, 3));
        put(CH_QUOTE);
        repeat ($urandom_range(0, 3)) put(text_byte());
        put(CH_NUL);
      end
      default: begin
        put(CH_LBRACE);
        repeat (MAX_PROPS + 1) put_pair(KEY_PLAIN, 1);
      end
    endcase
  endtask

  initial begin : stimulus
    int  seg_end;
    bit  full_done;
    full_done = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    write_fold(1'b1);

    // hand-written entity: odd whitespace, stray brace, mixed-case classname,
    // a high-bit value byte, empty key and value
    put(8'd11);
    put(CH_LBRACE);
    put(8'd12);
    put(CH_LBRACE);
    put(CH_QUOTE);
    put_word("ClAsSnAmE");
    put(CH_QUOTE);
    put(8'd9);
    put(CH_QUOTE);
    put(8'hff);
    put(CH_QUOTE);
    put(CH_QUOTE);
    put(CH_QUOTE);
    put(CH_QUOTE);
    put(CH_QUOTE);
    put(8'd13);
    put(CH_RBRACE);

    write_fold(1'b0);
    squeeze_req = 1;
    while (n_sent < ITEMS) begin
      seg_end     = n_sent + 250;
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      while (n_sent < seg_end && n_sent < ITEMS) begin
        if (n_sent >= ITEMS - 120) calm = 1;
        if (!full_done && n_sent >= 400) begin
          put_entity(MAX_PROPS, 1);
          full_done = 1;
        end else begin
          put_entity($urandom_range(0, 6), 0);
        end
      end
      if (n_sent < ITEMS) write_fold($urandom_range(0, 1));
    end
    calm = 1;
    finish_lump(lump_end_t'($urandom_range(0, int'(END_PROPS_FULL))));
    // halted: these must produce nothing
    repeat (24) put($urandom_range(0, 255));
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/elkv_pkg.sv
src/entity_lump_kv_parser_core.sv
test/elkv_event_checker.sv
test/tb_entity_lump_kv_parser_core.sv
